// ----- rtl/core/sccf_pkg.sv -----
// shared types and constants for the stepper command can framer
// depends on nothing; used by sccf_front, sccf_queue, sccf_back and the top level
package sccf_pkg;

  // command kinds carried on the input tuser
  typedef enum logic [2:0] {
    OP_ENABLE      = 3'd0,
    OP_STOP        = 3'd1,
    OP_VELOCITY    = 3'd2,
    OP_POSITION    = 3'd3,
    OP_SET_MODE    = 3'd4,
    OP_CLEAR_STALL = 3'd5,
    OP_SYNC        = 3'd6
  } op_e;

  // function codes and fixed bytes of the command set
  localparam logic [7:0] CMD_END        = 8'h6B;
  localparam logic [7:0] FC_ENABLE      = 8'hF3;
  localparam logic [7:0] SUB_ENABLE     = 8'hAB;
  localparam logic [7:0] FC_STOP        = 8'hFE;
  localparam logic [7:0] SUB_STOP       = 8'h98;
  localparam logic [7:0] FC_VELOCITY    = 8'hF6;
  localparam logic [7:0] FC_POSITION    = 8'hFD;
  localparam logic [7:0] FC_SET_MODE    = 8'h46;
  localparam logic [7:0] SUB_SET_MODE   = 8'h69;
  localparam logic [7:0] FC_CLEAR_STALL = 8'h0E;
  localparam logic [7:0] SUB_CLR_STALL  = 8'h52;
  localparam logic [7:0] FC_SYNC        = 8'hFF;
  localparam logic [7:0] SUB_SYNC       = 8'h66;

  // stream widths
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 88;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified command, ready to be framed
  typedef struct packed {
    logic [7:0]  addr;
    logic [63:0] f0_payload;
    logic [3:0]  f0_count;
    logic [63:0] f1_payload;
    logic [3:0]  f1_count;
    logic        two_frames;
  } entry_t;

  // one outgoing can frame
  typedef struct packed {
    logic [15:0] frame_id;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic        last_frame;
  } frame_t;

endpackage

// ----- rtl/core/sccf_front.sv -----
// front end: unpacks an input transaction and builds the command bytes of both frames
// depends on sccf_pkg
module sccf_front (
  input  logic [sccf_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [sccf_pkg::IN_USER_W-1:0] in_user_i,
  output logic                           known_o,
  output sccf_pkg::entry_t               entry_o
);

  logic [7:0]  dir;
  logic [15:0] spd;
  logic [7:0]  acc;
  logic [31:0] pc;
  logic        absf;
  logic        snf;
  logic        en;
  logic        sv;
  logic [7:0]  mode;
  sccf_pkg::op_e op;

  assign dir  = in_data_i[15:8];
  assign spd  = in_data_i[31:16];
  assign acc  = in_data_i[39:32];
  assign pc   = in_data_i[71:40];
  assign absf = in_data_i[72];
  assign snf  = in_data_i[73];
  assign en   = in_data_i[74];
  assign sv   = in_data_i[75];
  assign mode = in_data_i[83:76];
  assign op   = sccf_pkg::op_e'(in_user_i);

  always_comb begin
    known_o             = 1'b1;
    entry_o.addr        = in_data_i[7:0];
    entry_o.f0_payload  = '0;
    entry_o.f0_count    = 4'd0;
    entry_o.f1_payload  = '0;
    entry_o.f1_count    = 4'd0;
    entry_o.two_frames  = 1'b0;
    unique case (op)
      sccf_pkg::OP_ENABLE: begin
        entry_o.f0_payload = {24'h0, sccf_pkg::CMD_END, 7'h0, snf, 7'h0, en,
                              sccf_pkg::SUB_ENABLE, sccf_pkg::FC_ENABLE};
        entry_o.f0_count   = 4'd5;
      end
      sccf_pkg::OP_STOP: begin
        entry_o.f0_payload = {32'h0, sccf_pkg::CMD_END, 7'h0, snf,
                              sccf_pkg::SUB_STOP, sccf_pkg::FC_STOP};
        entry_o.f0_count   = 4'd4;
      end
      sccf_pkg::OP_VELOCITY: begin
        entry_o.f0_payload = {8'h0, sccf_pkg::CMD_END, 7'h0, snf, acc, spd[7:0],
                              spd[15:8], dir, sccf_pkg::FC_VELOCITY};
        entry_o.f0_count   = 4'd7;
      end
      sccf_pkg::OP_POSITION: begin
        // first eight bytes, then the function code again with the tail
        entry_o.f0_payload = {pc[15:8], pc[23:16], pc[31:24], acc, spd[7:0],
                              spd[15:8], dir, sccf_pkg::FC_POSITION};
        entry_o.f0_count   = 4'd8;
        entry_o.f1_payload = {24'h0, sccf_pkg::CMD_END, 7'h0, snf, 7'h0, absf,
                              pc[7:0], sccf_pkg::FC_POSITION};
        entry_o.f1_count   = 4'd5;
        entry_o.two_frames = 1'b1;
      end
      sccf_pkg::OP_SET_MODE: begin
        entry_o.f0_payload = {24'h0, sccf_pkg::CMD_END, mode, 7'h0, sv,
                              sccf_pkg::SUB_SET_MODE, sccf_pkg::FC_SET_MODE};
        entry_o.f0_count   = 4'd5;
      end
      sccf_pkg::OP_CLEAR_STALL: begin
        entry_o.f0_payload = {40'h0, sccf_pkg::CMD_END, sccf_pkg::SUB_CLR_STALL,
                              sccf_pkg::FC_CLEAR_STALL};
        entry_o.f0_count   = 4'd3;
      end
      sccf_pkg::OP_SYNC: begin
        entry_o.f0_payload = {40'h0, sccf_pkg::CMD_END, sccf_pkg::SUB_SYNC,
                              sccf_pkg::FC_SYNC};
        entry_o.f0_count   = 4'd3;
      end
      default: begin
        // unused opcode, dropped
        known_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/sccf_queue.sv -----
// short command queue between the front end and the frame sequencer
// depends on sccf_pkg
module sccf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sccf_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sccf_pkg::entry_t head_o
);

  sccf_pkg::entry_t                  mem_q [sccf_pkg::QUEUE_DEPTH];
  logic [sccf_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [sccf_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [sccf_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                              do_push, do_pop;

  localparam logic [sccf_pkg::QPTR_W-1:0] LastPtr =
    sccf_pkg::QPTR_W'(sccf_pkg::QUEUE_DEPTH - 1);
  localparam logic [sccf_pkg::QCNT_W-1:0] FullCount =
    sccf_pkg::QCNT_W'(sccf_pkg::QUEUE_DEPTH);

  assign full_o  = (count_q == FullCount);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- rtl/core/sccf_back.sv -----
// back end: walks the frames of the queue head into the output register
// depends on sccf_pkg
module sccf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  sccf_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sccf_pkg::frame_t out_frame_o
);

  logic             valid_q, valid_d;
  logic             second_q, second_d;
  sccf_pkg::frame_t frame_q, frame_d;
  logic             load;

  // output register may take a new frame when empty or being drained
  assign load = head_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    frame_d  = frame_q;
    pop_o    = 1'b0;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      if (!second_q) begin
        frame_d.frame_id   = {head_i.addr, 8'd0};
        frame_d.byte_count = head_i.f0_count;
        frame_d.payload    = head_i.f0_payload;
        frame_d.last_frame = !head_i.two_frames;
        second_d           = head_i.two_frames;
        pop_o              = !head_i.two_frames;
      end else begin
        frame_d.frame_id   = {head_i.addr, 8'd1};
        frame_d.byte_count = head_i.f1_count;
        frame_d.payload    = head_i.f1_payload;
        frame_d.last_frame = 1'b1;
        second_d           = 1'b0;
        pop_o              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign out_valid_o = valid_q;
  assign out_frame_o = frame_q;

endmodule

// ----- rtl/core/stepper_command_can_framer.sv -----
// top level of the stepper command can framer
// depends on sccf_pkg, sccf_front, sccf_queue and sccf_back
//
// usage:
//   the slave stream carries one stepper command per transaction: the command kind
//   on s_axis_tuser_i and its operands packed in s_axis_tdata_i. the master stream
//   gives one can frame per transaction: id, data length code and data bytes in
//   m_axis_tdata_o, with m_axis_tlast_o high on the final frame of a command.
//   the position command yields two frames, every other command one frame, and
//   an unused command kind is taken and dropped without a frame.
// first frame: a command enters the two-entry queue at the accepting edge, and its first
//   frame is loaded from the queue head into the output register once that is free.
// throughput: one frame per cycle while m_axis_tready_i is high, set by the single
//   output register; a position command gives two frames. new commands are taken while
//   frames of earlier ones are still waiting, as long as the queue has room.
// reset: rst_ni clears the queue, the frame sequencer and the output valid; no
//   clearing pass is needed, the block accepts right after reset.
// stall: when m_axis_tready_i is low the frame holds in the output register, the
//   queue fills, and s_axis_tready_o drops once both queue entries are taken.
module stepper_command_can_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave stream: commands
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // motor_addr[7:0], direction[15:8], speed[31:16], accel[39:32],
  // pulse_count[71:40], absolute[72], sync_flag[73], enable[74], save[75],
  // loop_mode[83:76], zero fill[87:84]
  input  logic [sccf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode[2:0]
  input  logic [sccf_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  // master stream: can frames
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // frame_id[15:0], byte_count[19:16], payload[83:20], zero fill[87:84]
  output logic [sccf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // last_frame
  output logic                            m_axis_tlast_o
);

  logic             known;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             q_push;
  sccf_pkg::entry_t front_entry;
  sccf_pkg::entry_t head_entry;
  sccf_pkg::frame_t out_frame;

  // classify and build command bytes
  sccf_front u_front (
    .in_data_i (s_axis_tdata_i),
    .in_user_i (s_axis_tuser_i),
    .known_o   (known),
    .entry_o   (front_entry)
  );

  // taking a transaction only needs room in the queue; unused kinds are not queued
  assign s_axis_tready_o = !q_full;
  assign q_push          = s_axis_tvalid_i && !q_full && known;

  sccf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (head_entry)
  );

  // frame sequencer and output register
  sccf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_entry),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_frame_o  (out_frame)
  );

  assign m_axis_tdata_o = {4'h0, out_frame.payload, out_frame.byte_count, out_frame.frame_id};
  assign m_axis_tlast_o = out_frame.last_frame;

endmodule

// ----- tb/sv/frame_checker.sv -----
// scoreboard for the stepper command can framer: predicts the can frames of every
// command taken on the slave stream and compares them with the master stream
// depends on sccf_pkg for the command kinds, the command bytes and frame_t
module frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [87:0] cmd_data_i,
  input  logic [2:0]  cmd_kind_i,
  input  logic        frame_valid_i,
  input  logic        frame_ready_i,
  input  logic [87:0] frame_data_i,
  input  logic        frame_last_i,
  output int          mismatch_count_o,
  output int          frames_pending_o,
  output int          commands_taken_o,
  output int          frames_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  sccf_pkg::frame_t frames_due [$];

  // command bytes of one command, cut into at most two frames
  function automatic int unsigned frame_command(input logic [2:0] kind,
                                                input logic [87:0] cmd,
                                                output sccf_pkg::frame_t first,
                                                output sccf_pkg::frame_t second);
    logic [7:0]  cmd_bytes [0:11];
    int unsigned len;
    int unsigned first_len;
    logic [7:0]  addr;
    addr = cmd[7:0];
    first = '0;
    second = '0;
    len = 0;
    foreach (cmd_bytes[i]) cmd_bytes[i] = '0;
    case (kind)
      sccf_pkg::OP_ENABLE: begin
        cmd_bytes[0] = sccf_pkg::FC_ENABLE;
        cmd_bytes[1] = sccf_pkg::SUB_ENABLE;
        cmd_bytes[2] = {7'd0, cmd[74]};
        cmd_bytes[3] = {7'd0, cmd[73]};
        cmd_bytes[4] = sccf_pkg::CMD_END;
        len = 5;
      end
      sccf_pkg::OP_STOP: begin
        cmd_bytes[0] = sccf_pkg::FC_STOP;
        cmd_bytes[1] = sccf_pkg::SUB_STOP;
        cmd_bytes[2] = {7'd0, cmd[73]};
        cmd_bytes[3] = sccf_pkg::CMD_END;
        len = 4;
      end
      sccf_pkg::OP_VELOCITY: begin
        cmd_bytes[0] = sccf_pkg::FC_VELOCITY;
        cmd_bytes[1] = cmd[15:8];
        cmd_bytes[2] = cmd[31:24];
        cmd_bytes[3] = cmd[23:16];
        cmd_bytes[4] = cmd[39:32];
        cmd_bytes[5] = {7'd0, cmd[73]};
        cmd_bytes[6] = sccf_pkg::CMD_END;
        len = 7;
      end
      sccf_pkg::OP_POSITION: begin
        cmd_bytes[0]  = sccf_pkg::FC_POSITION;
        cmd_bytes[1]  = cmd[15:8];
        cmd_bytes[2]  = cmd[31:24];
        cmd_bytes[3]  = cmd[23:16];
        cmd_bytes[4]  = cmd[39:32];
        cmd_bytes[5]  = cmd[71:64];
        cmd_bytes[6]  = cmd[63:56];
        cmd_bytes[7]  = cmd[55:48];
        cmd_bytes[8]  = cmd[47:40];
        cmd_bytes[9]  = {7'd0, cmd[72]};
        cmd_bytes[10] = {7'd0, cmd[73]};
        cmd_bytes[11] = sccf_pkg::CMD_END;
        len = 12;
      end
      sccf_pkg::OP_SET_MODE: begin
        cmd_bytes[0] = sccf_pkg::FC_SET_MODE;
        cmd_bytes[1] = sccf_pkg::SUB_SET_MODE;
        cmd_bytes[2] = {7'd0, cmd[75]};
        cmd_bytes[3] = cmd[83:76];
        cmd_bytes[4] = sccf_pkg::CMD_END;
        len = 5;
      end
      sccf_pkg::OP_CLEAR_STALL: begin
        cmd_bytes[0] = sccf_pkg::FC_CLEAR_STALL;
        cmd_bytes[1] = sccf_pkg::SUB_CLR_STALL;
        cmd_bytes[2] = sccf_pkg::CMD_END;
        len = 3;
      end
      sccf_pkg::OP_SYNC: begin
        cmd_bytes[0] = sccf_pkg::FC_SYNC;
        cmd_bytes[1] = sccf_pkg::SUB_SYNC;
        cmd_bytes[2] = sccf_pkg::CMD_END;
        len = 3;
      end
      default: return 0;
    endcase
    first_len = (len > 8) ? 8 : len;
    first.frame_id = {addr, 8'd0};
    first.byte_count = 4'(first_len);
    for (int i = 0; i < first_len; i++) first.payload[8*i +: 8] = cmd_bytes[i];
    first.last_frame = (len <= 8);
    if (len <= 8) return 1;
    // later frame repeats the function code, then the rest of the bytes
    second.frame_id = {addr, 8'd1};
    second.byte_count = 4'(len - 8 + 1);
    second.payload[7:0] = cmd_bytes[0];
    for (int i = 8; i < len; i++) second.payload[8*(i-7) +: 8] = cmd_bytes[i];
    second.last_frame = 1'b1;
    return 2;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] have);
    mismatch_count_o++;
    if (mismatch_count_o <= MAX_REPORTS)
      $display("mismatch at frame %0d: %s expected %h got %h",
               frames_seen_o, what, want, have);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sccf_pkg::frame_t due_a;
    sccf_pkg::frame_t due_b;
    sccf_pkg::frame_t got;
    int unsigned      produced;
    if (!rst_ni) begin
      frames_due.delete();
      mismatch_count_o = 0;
      frames_pending_o = 0;
      commands_taken_o = 0;
      frames_seen_o = 0;
    end else begin
      if (cmd_valid_i && cmd_ready_i) begin
        commands_taken_o++;
        produced = frame_command(cmd_kind_i, cmd_data_i, due_a, due_b);
        if (produced >= 1) frames_due.push_back(due_a);
        if (produced >= 2) frames_due.push_back(due_b);
      end
      if (frame_valid_i && frame_ready_i) begin
        got.frame_id = frame_data_i[15:0];
        got.byte_count = frame_data_i[19:16];
        got.payload = frame_data_i[83:20];
        got.last_frame = frame_last_i;
        if (frames_due.size() == 0) begin
          note_mismatch("frame with nothing due, id", '0, 64'(got.frame_id));
        end else begin
          due_a = frames_due.pop_front();
          if (got.frame_id !== due_a.frame_id)
            note_mismatch("frame_id", 64'(due_a.frame_id), 64'(got.frame_id));
          if (got.byte_count !== due_a.byte_count)
            note_mismatch("byte_count", 64'(due_a.byte_count), 64'(got.byte_count));
          if (got.payload !== due_a.payload)
            note_mismatch("payload", due_a.payload, got.payload);
          if (got.last_frame !== due_a.last_frame)
            note_mismatch("last_frame", 64'(due_a.last_frame), 64'(got.last_frame));
        end
        frames_seen_o++;
      end
      frames_pending_o = frames_due.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// top of the framer testbench: clock, reset, command stimulus and frame back-pressure
// depends on sccf_pkg, stepper_command_can_framer and frame_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // the one command kind the block takes and drops without a frame
  localparam logic [2:0]  OP_UNUSED       = 3'd7;
  localparam int          RANDOM_COMMANDS = 950;
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          CYCLE_LIMIT     = 1_000_000;
  // spare cycles after the last due frame has gone out, to catch strays
  localparam int          DRAIN_CYCLES    = 8;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid_i;
  logic                            s_axis_tready_o;
  logic [sccf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [sccf_pkg::IN_USER_W-1:0]  s_axis_tuser_i;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i;
  logic [sccf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tlast_o;

  int mismatches;
  int frames_pending;
  int commands_taken;
  int frames_seen;

  // shared between the command driver and the frame receiver
  logic calm;           // no idling on either side while set
  logic hold_off_req;   // receiver holds tready low for a long stretch
  int   cycle_count = 0;
  int   position_sent;
  int   unused_sent;

  always #2ns clk_i = ~clk_i;

  stepper_command_can_framer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (s_axis_tvalid_i),
    .cmd_ready_i      (s_axis_tready_o),
    .cmd_data_i       (s_axis_tdata_i),
    .cmd_kind_i       (s_axis_tuser_i),
    .frame_valid_i    (m_axis_tvalid_o),
    .frame_ready_i    (m_axis_tready_i),
    .frame_data_i     (m_axis_tdata_o),
    .frame_last_i     (m_axis_tlast_o),
    .mismatch_count_o (mismatches),
    .frames_pending_o (frames_pending),
    .commands_taken_o (commands_taken),
    .frames_seen_o    (frames_seen)
  );

  // operands in slave tdata order, lowest field first, zero fill on top
  function automatic logic [87:0] pack_command(input logic [7:0] addr, input logic [7:0] dir,
                                               input logic [15:0] speed,
                                               input logic [7:0] accel,
                                               input logic [31:0] pulses,
                                               input logic absolute, input logic sync_flag,
                                               input logic enable, input logic save,
                                               input logic [7:0] mode);
    return {4'd0, mode, save, enable, sync_flag, absolute, pulses, accel, speed, dir, addr};
  endfunction

  function automatic logic [87:0] random_operands();
    return pack_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                        32'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)));
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offers one command from a falling edge and returns at the falling edge after
  // the accepting rising edge; valid stays high when no gap follows
  task automatic send_command(input logic [2:0] kind, input logic [87:0] operands);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) begin
        // junk on the bus while idle must be ignored
        s_axis_tdata_i = random_operands();
        s_axis_tuser_i = 3'($urandom_range(0, 7));
        @(negedge clk_i);
      end
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = operands;
    s_axis_tuser_i = kind;
    if (kind == sccf_pkg::OP_POSITION) position_sent++;
    if (kind == OP_UNUSED) unused_sent++;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d frames still due", cycle_count,
               frames_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // frame receiver: random back-pressure, a long hold-off on request
  initial begin
    int low_run;
    low_run = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_axis_tready_i = 1'b0;
      end else if (hold_off_req) begin
        // the queue fills behind the held frame and the slave side stalls
        m_axis_tready_i = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (calm) begin
        m_axis_tready_i = 1'b1;
      end else if (low_run > 0) begin
        m_axis_tready_i = 1'b0;
        low_run--;
      end else if ($urandom_range(0, 99) < 70) begin
        m_axis_tready_i = 1'b1;
      end else begin
        m_axis_tready_i = 1'b0;
        low_run = pick_gap();
      end
    end
  end

  // command stimulus
  initial begin
    int          offered;
    int          counted;
    int          r;
    logic [2:0]  kind;
    position_sent = 0;
    unused_sent = 0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every command kind, field extremes, byte order, unused kind
    send_command(sccf_pkg::OP_ENABLE, pack_command(8'h00, 8'h00, 16'h0000, 8'h00, 32'h0,
                                                   1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    send_command(sccf_pkg::OP_ENABLE, pack_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                                   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1,
                                                   8'hFF));
    send_command(sccf_pkg::OP_STOP, pack_command(8'h01, 8'h00, 16'h0000, 8'h00, 32'h0,
                                                 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    send_command(sccf_pkg::OP_STOP, pack_command(8'hFF, 8'hAA, 16'h5555, 8'h33,
                                                 32'hCAFE_F00D, 1'b1, 1'b1, 1'b1, 1'b1,
                                                 8'hA5));
    send_command(sccf_pkg::OP_VELOCITY, pack_command(8'h00, 8'h00, 16'h0000, 8'h00, 32'h0,
                                                     1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    send_command(sccf_pkg::OP_VELOCITY, pack_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                                     32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                                                     8'hFF));
    // speed bytes distinct so a swapped byte order shows
    send_command(sccf_pkg::OP_VELOCITY, pack_command(8'h12, 8'h01, 16'h0BB8, 8'h0A, 32'h0,
                                                     1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
    send_command(sccf_pkg::OP_POSITION, pack_command(8'h00, 8'h00, 16'h0000, 8'h00, 32'h0,
                                                     1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    send_command(sccf_pkg::OP_POSITION, pack_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                                     32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                                                     8'hFF));
    send_command(sccf_pkg::OP_POSITION, pack_command(8'h34, 8'h01, 16'h1234, 8'h56,
                                                     32'h1234_5678, 1'b1, 1'b0, 1'b0, 1'b0,
                                                     8'h00));
    send_command(sccf_pkg::OP_POSITION, pack_command(8'h80, 8'h00, 16'h8001, 8'h00,
                                                     32'h8000_0001, 1'b0, 1'b1, 1'b0, 1'b0,
                                                     8'h00));
    send_command(sccf_pkg::OP_SET_MODE, pack_command(8'h00, 8'h00, 16'h0000, 8'h00, 32'h0,
                                                     1'b0, 1'b0, 1'b0, 1'b1, 8'hFF));
    send_command(sccf_pkg::OP_SET_MODE, pack_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                                     32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0,
                                                     8'h00));
    send_command(sccf_pkg::OP_SET_MODE, pack_command(8'h07, 8'h00, 16'h0000, 8'h00, 32'h0,
                                                     1'b0, 1'b0, 1'b0, 1'b0, 8'h02));
    send_command(sccf_pkg::OP_CLEAR_STALL, pack_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                                        32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                                                        1'b1, 8'hFF));
    send_command(sccf_pkg::OP_CLEAR_STALL, pack_command(8'h00, 8'h00, 16'h0000, 8'h00,
                                                        32'h0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                        8'h00));
    send_command(sccf_pkg::OP_SYNC, pack_command(8'h00, 8'h00, 16'h0000, 8'h00, 32'h0,
                                                 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    send_command(sccf_pkg::OP_SYNC, pack_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                                                 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                                                 8'hFF));
    // unused kind is taken and dropped, between framed commands
    send_command(OP_UNUSED, pack_command(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
                                         1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
    send_command(sccf_pkg::OP_STOP, random_operands());
    send_command(OP_UNUSED, random_operands());

    // random: position weighted up since it is the only two-frame command
    offered = 0;
    counted = 0;
    while (counted < RANDOM_COMMANDS) begin
      if (offered == 100 || offered == 650) hold_off_req = 1'b1;
      calm = (offered >= 300 && offered < 420);
      r = $urandom_range(0, 99);
      if (r < 5) kind = OP_UNUSED;
      else if (r < 30) kind = sccf_pkg::OP_POSITION;
      else kind = 3'($urandom_range(sccf_pkg::OP_ENABLE, sccf_pkg::OP_SYNC));
      send_command(kind, random_operands());
      offered++;
      if (kind != OP_UNUSED) counted++;
    end
    s_axis_tvalid_i = 1'b0;
    calm = 1'b0;

    // drain: every due frame out, then DRAIN_CYCLES more for anything extra
    while (frames_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands (%0d position, %0d unused kind) and %0d frames",
             commands_taken, position_sent, unused_sent, frames_seen);
    $display("in %0d cycles with random idling, a calm stretch and two long output stalls",
             cycle_count);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
